// ----- rtl/aht_pkg.sv -----
// Package: shared types and character constants for the HTML attribute tokenizer.
`timescale 1ns / 1ps
package aht_pkg;

  // Character codes the lexer looks for
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // '\''
  localparam logic [7:0] CH_HYPHEN = 8'h2D;  // '-'

  // Most tokens one byte can produce
  localparam int unsigned MaxTokens = 3;

  typedef enum logic [2:0] {
    M_BEFORE    = 3'd0,
    M_KEY       = 3'd1,
    M_AFTER_KEY = 3'd2,
    M_AFTER_EQ  = 3'd3,
    M_VALUE     = 3'd4,
    M_DONE      = 3'd5
  } lex_mode_t;

  typedef enum logic [1:0] {
    K_KEY_CHAR   = 2'd0,
    K_VALUE_CHAR = 2'd1,
    K_ATTR_END   = 2'd2,
    K_STOP       = 2'd3
  } tok_kind_t;

  typedef enum logic [1:0] {
    VS_NONE   = 2'd0,
    VS_QUOTED = 2'd1,
    VS_UNTERM = 2'd2
  } val_status_t;

  typedef enum logic [1:0] {
    SC_GT    = 2'd0,
    SC_SLASH = 2'd1,
    SC_BAD   = 2'd2,
    SC_EOI   = 2'd3
  } stop_cause_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  ch;
    val_status_t status;
    stop_cause_t cause;
    logic        last;
  } token_t;

  // Tokens produced by one accepted byte, in order, slot 0 first
  typedef struct packed {
    logic                  wr;
    logic [1:0]            count;
    token_t [MaxTokens-1:0] tok;
  } tok_group_t;

endpackage

// ----- rtl/aht_if.sv -----
// Interfaces: byte input channel and token output channel.
`timescale 1ns / 1ps
interface aht_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       begin_tag;
  logic       end_of_input;

  modport source(output valid, in_byte, begin_tag, end_of_input, input ready);
  modport sink(input valid, in_byte, begin_tag, end_of_input, output ready);
endinterface

interface aht_token_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] token_char;
  logic [1:0] value_status;
  logic [1:0] stop_cause;
  logic       run_last;

  modport source(output valid, token_kind, token_char, value_status, stop_cause, run_last,
                 input ready);
  modport sink(input valid, token_kind, token_char, value_status, stop_cause, run_last,
               output ready);
endinterface

// ----- rtl/html_attribute_tokenizer.sv -----
// Top level of the HTML tag attribute tokenizer.
// Takes one byte of a tag body per beat on bytes and returns key characters
// (lowercased), quoted value characters, attribute ends and one stop per tag on
// tokens, one token per beat, with run_last marking the final token of a byte.
// A byte is accepted in any cycle in which the token queue has three free slots,
// so bytes stream at one per cycle while the queue drains; a byte's tokens reach
// the queue head at the earliest in the cycle after it is accepted. Sustained rate
// is bounded by the token side at one token per cycle, so bytes giving more than
// one token slow the input to match. DEPTH sets the queue size (at least 4).
`timescale 1ns / 1ps
module html_attribute_tokenizer #(
  parameter int unsigned DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  aht_byte_if.sink     bytes,
  aht_token_if.source  tokens
);

  aht_pkg::tok_group_t group;
  aht_pkg::token_t     head;
  logic                has_room;
  logic                head_valid;
  logic                accept;

  assign bytes.ready = has_room;
  assign accept      = bytes.valid && has_room;

  aht_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (bytes.in_byte),
    .begin_tag    (bytes.begin_tag),
    .end_of_input (bytes.end_of_input),
    .group        (group)
  );

  aht_queue #(.DEPTH(DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .group      (group),
    .has_room   (has_room),
    .head_valid (head_valid),
    .head_take  (tokens.ready),
    .head       (head)
  );

  // Token channel straight off the queue head
  assign tokens.valid        = head_valid;
  assign tokens.token_kind   = head.kind;
  assign tokens.token_char   = head.ch;
  assign tokens.value_status = head.status;
  assign tokens.stop_cause   = head.cause;
  assign tokens.run_last     = head.last;

endmodule

// ----- rtl/aht_lexer.sv -----
// Lexer core: mode register and the per-byte token decode.
`timescale 1ns / 1ps
module aht_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                begin_tag,
  input  logic                end_of_input,
  output aht_pkg::tok_group_t group
);

  typedef struct packed {
    logic              emit;
    aht_pkg::token_t   tok;
    aht_pkg::lex_mode_t mode;
  } bk_res_t;

  aht_pkg::lex_mode_t lex_mode, lex_mode_next;
  logic               quote_is_single, quote_is_single_next;

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_key_char(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || (c == aht_pkg::CH_HYPHEN);
  endfunction

  function automatic aht_pkg::token_t mk_tok(aht_pkg::tok_kind_t k, logic [7:0] ch,
                                             aht_pkg::val_status_t s,
                                             aht_pkg::stop_cause_t sc);
    aht_pkg::token_t t;
    t.kind   = k;
    t.ch     = ch;
    t.status = s;
    t.cause  = sc;
    t.last   = 1'b0;
    return t;
  endfunction

  // Handling of a byte where a key may start; white space leaves the mode alone
  function automatic bk_res_t before_key(logic [7:0] c);
    bk_res_t r;
    r.emit = 1'b1;
    r.mode = aht_pkg::M_DONE;
    r.tok  = mk_tok(aht_pkg::K_STOP, 8'd0, aht_pkg::VS_NONE, aht_pkg::SC_BAD);
    priority if (is_ws(c)) begin
      r.emit = 1'b0;
      r.mode = aht_pkg::M_BEFORE;
    end else if (c == aht_pkg::CH_GT) begin
      r.tok.cause = aht_pkg::SC_GT;
    end else if (c == aht_pkg::CH_SLASH) begin
      r.tok.cause = aht_pkg::SC_SLASH;
    end else if (is_key_char(c)) begin
      r.tok  = mk_tok(aht_pkg::K_KEY_CHAR, (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c,
                      aht_pkg::VS_NONE, aht_pkg::SC_GT);
      r.mode = aht_pkg::M_KEY;
    end else begin
      // anything else cannot start a key
      r.tok.cause = aht_pkg::SC_BAD;
    end
    return r;
  endfunction

  // Per-byte decode: up to four candidate tokens, packed into at most three slots
  always_comb begin
    aht_pkg::lex_mode_t  mode_cur;
    aht_pkg::lex_mode_t  mode_mid;
    logic                qs_cur;
    bk_res_t             bk;
    logic                cand_v [4];
    aht_pkg::token_t     cand [4];
    logic [1:0]          n;
    logic [7:0]          c;
    logic                use_bk;
    logic                end0;

    c        = in_byte;
    mode_cur = begin_tag ? aht_pkg::M_BEFORE : lex_mode;
    qs_cur   = begin_tag ? 1'b0 : quote_is_single;
    bk       = before_key(c);
    use_bk   = 1'b0;
    end0     = 1'b0;
    mode_mid = mode_cur;
    quote_is_single_next = qs_cur;
    for (int i = 0; i < 4; i++) begin
      cand_v[i] = 1'b0;
      cand[i]   = mk_tok(aht_pkg::K_KEY_CHAR, 8'd0, aht_pkg::VS_NONE, aht_pkg::SC_GT);
    end

    unique case (mode_cur)
      aht_pkg::M_BEFORE: use_bk = 1'b1;
      aht_pkg::M_KEY: begin
        if (is_ws(c)) mode_mid = aht_pkg::M_AFTER_KEY;
        else if (c == aht_pkg::CH_EQ) mode_mid = aht_pkg::M_AFTER_EQ;
        else use_bk = 1'b1;
      end
      aht_pkg::M_AFTER_KEY: begin
        if (is_ws(c)) mode_mid = mode_cur;
        else if (c == aht_pkg::CH_EQ) mode_mid = aht_pkg::M_AFTER_EQ;
        else begin
          end0   = is_key_char(c);
          use_bk = 1'b1;
        end
      end
      aht_pkg::M_AFTER_EQ: begin
        if (is_ws(c)) mode_mid = mode_cur;
        else if (c == aht_pkg::CH_DQUOTE || c == aht_pkg::CH_SQUOTE) begin
          quote_is_single_next = (c == aht_pkg::CH_SQUOTE);
          mode_mid = aht_pkg::M_VALUE;
        end else begin
          end0   = is_key_char(c);
          use_bk = 1'b1;
        end
      end
      aht_pkg::M_VALUE: begin
        if (c == (qs_cur ? aht_pkg::CH_SQUOTE : aht_pkg::CH_DQUOTE)) begin
          cand_v[1] = 1'b1;
          cand[1]   = mk_tok(aht_pkg::K_ATTR_END, 8'd0, aht_pkg::VS_QUOTED, aht_pkg::SC_GT);
          mode_mid  = aht_pkg::M_BEFORE;
        end else begin
          cand_v[1] = 1'b1;
          cand[1]   = mk_tok(aht_pkg::K_VALUE_CHAR, c, aht_pkg::VS_NONE, aht_pkg::SC_GT);
        end
      end
      default: mode_mid = aht_pkg::M_DONE;
    endcase

    // Attribute end for a key left without a value, then the key-start decode
    if (end0) begin
      cand_v[0] = 1'b1;
      cand[0]   = mk_tok(aht_pkg::K_ATTR_END, 8'd0, aht_pkg::VS_NONE, aht_pkg::SC_GT);
    end
    if (use_bk) begin
      cand_v[1] = bk.emit;
      cand[1]   = bk.tok;
      mode_mid  = bk.mode;
    end

    // End of input closes whatever is open
    lex_mode_next = mode_mid;
    if (end_of_input && mode_mid != aht_pkg::M_DONE) begin
      if (mode_mid == aht_pkg::M_VALUE) begin
        cand_v[2] = 1'b1;
        cand[2]   = mk_tok(aht_pkg::K_ATTR_END, 8'd0, aht_pkg::VS_UNTERM, aht_pkg::SC_GT);
      end
      cand_v[3] = 1'b1;
      cand[3]   = mk_tok(aht_pkg::K_STOP, 8'd0, aht_pkg::VS_NONE, aht_pkg::SC_EOI);
      lex_mode_next = aht_pkg::M_DONE;
    end

    // Pack into slots and mark the last one
    n = 2'd0;
    group.tok = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && n != 2'd3) begin
        group.tok[n] = cand[i];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) group.tok[n - 2'd1].last = 1'b1;
    group.count = n;
    group.wr    = accept && (n != 2'd0);
  end

  // Mode and quote registers advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode        <= aht_pkg::M_BEFORE;
      quote_is_single <= 1'b0;
    end else if (accept) begin
      lex_mode        <= lex_mode_next;
      quote_is_single <= quote_is_single_next;
    end
  end

endmodule

// ----- rtl/aht_queue.sv -----
// Token queue: takes up to three tokens per cycle, hands out one per beat.
`timescale 1ns / 1ps
module aht_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  aht_pkg::tok_group_t group,
  output logic                has_room,
  output logic                head_valid,
  input  logic                head_take,
  output aht_pkg::token_t     head
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW:0] DepthW = (PtrW + 1)'(DEPTH);
  localparam logic [CntW-1:0] RoomLimit = CntW'(DEPTH - aht_pkg::MaxTokens);

  aht_pkg::token_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] wr_n;
  logic            pop;

  function automatic logic [PtrW-1:0] wrap_add(logic [PtrW-1:0] p, logic [1:0] k);
    logic [PtrW:0] s;
    s = {1'b0, p} + (PtrW + 1)'(k);
    if (s >= DepthW) s = s - DepthW;
    return s[PtrW-1:0];
  endfunction

  assign has_room   = (count <= RoomLimit);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && head_take;
  assign wr_n       = group.wr ? CntW'(group.count) : '0;

  // Storage: tokens of one byte go into consecutive slots
  always_ff @(posedge clk) begin
    if (group.wr) begin
      for (int i = 0; i < aht_pkg::MaxTokens; i++) begin
        if (2'(i) < group.count) mem[wrap_add(wr_ptr, 2'(i))] <= group.tok[i];
      end
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (group.wr) wr_ptr <= wrap_add(wr_ptr, group.count);
      if (pop) rd_ptr <= wrap_add(rd_ptr, 2'd1);
      count <= count + wr_n - CntW'(pop);
    end
  end

endmodule

// ----- rtl/aht_checker.sv -----
// Port checker for the tokenizer, bound onto the top level.
`timescale 1ns / 1ps
module aht_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] token_kind,
  input logic [7:0] token_char,
  input logic [1:0] value_status,
  input logic [1:0] stop_cause,
  input logic       run_last
);

  // A stalled token holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_char)
      && $stable(value_status) && $stable(stop_cause) && $stable(run_last))
    else $error("token changed while stalled");

  // Reset leaves the queue empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token valid right after reset");

  // A stop is always the final token of its byte
  a_stop_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == aht_pkg::K_STOP |-> run_last)
    else $error("stop token not marked last");

  // An unterminated value is always followed by the end-of-input stop
  a_unterm_then_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && token_kind == aht_pkg::K_ATTR_END
      && value_status == aht_pkg::VS_UNTERM
    |-> !run_last ##1 (out_valid && token_kind == aht_pkg::K_STOP
      && stop_cause == aht_pkg::SC_EOI))
    else $error("unterminated value not followed by end-of-input stop");

endmodule

bind html_attribute_tokenizer aht_checker u_aht_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .token_kind   (tokens.token_kind),
  .token_char   (tokens.token_char),
  .value_status (tokens.value_status),
  .stop_cause   (tokens.stop_cause),
  .run_last     (tokens.run_last)
);
